// File: hw/rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the letter column segmenter
// Register indexes, reset values, field widths and the result record.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_HEIGHT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WIDTH    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_NUMBER   = 2'd2;

  localparam int unsigned COLUMN_HEIGHT_W = 11;
  localparam int unsigned LINE_WIDTH_W    = 13;
  localparam int unsigned LINE_NUMBER_W   = 16;

  localparam logic [COLUMN_HEIGHT_W-1:0] COLUMN_HEIGHT_RST = 11'd32;
  localparam logic [LINE_WIDTH_W-1:0]    LINE_WIDTH_RST    = 13'd1024;
  localparam logic [LINE_NUMBER_W-1:0]   LINE_NUMBER_RST   = 16'd0;

  localparam int unsigned LETTER_INDEX_W  = 11;
  localparam int unsigned START_COLUMN_W  = 12;
  localparam int unsigned LETTER_WIDTH_W  = 13;
  localparam int unsigned TOP_ROW_W       = 10;
  localparam int unsigned LETTER_HEIGHT_W = 11;
  localparam int unsigned LINE_ID_W       = 16;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 80;

  // one reported letter, fields in tdata order
  typedef struct packed {
    logic [LINE_ID_W-1:0]       line_id;
    logic [LETTER_HEIGHT_W-1:0] letter_height;
    logic [TOP_ROW_W-1:0]       top_row;
    logic [LETTER_WIDTH_W-1:0]  letter_width;
    logic [START_COLUMN_W-1:0]  start_column;
    logic [LETTER_INDEX_W-1:0]  letter_index;
  } lcs_result_t;

endpackage

// File: hw/rtl/letter_column_segmenter.sv
// ----------------------------------------------------------------------------
// letter_column_segmenter: vertical projection letter segmentation
// Takes ink bits of a text line column by column and reports each letter.
// ----------------------------------------------------------------------------
//  channel  | dir | item
//  ---------+-----+-----------------------------------------------------------
//  in_      | in  | one pixel: ink bit
//  out_     | out | one letter: index, start, width, top, height, line id
//  cfg_     | in  | register write: column_height, line_width, line_number
//
//  one pixel per cycle sustained while out_ is not stalled
//  pixel register feeds the column/letter state, the letter goes to an output register
//  the pixel register advances whenever the output register is empty or drained
//  a stalled out_ holds the letter and stops the pixel path only then
//  synchronous active-low reset clears counters, letter state and valids
//  registers reset to 32 rows, 1024 columns, line 0
// ----------------------------------------------------------------------------
module letter_column_segmenter import lcs_pkg::*; #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // pixel stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] ink, rest zero
  // letter stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // letter_index, start_column,
                                              // letter_width, top_row,
                                              // letter_height, line_id, pad
  // register writes
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [COLUMN_HEIGHT_W-1:0] column_height_r;
  logic [LINE_WIDTH_W-1:0]    line_width_r;
  logic [LINE_NUMBER_W-1:0]   line_number_r;

  logic        pix_valid_r, pix_valid_nxt;
  logic        pix_ink_r;
  logic        out_valid_r, out_valid_nxt;
  lcs_result_t out_res_r;

  logic        out_free;
  logic        step;
  logic        res_valid;
  lcs_result_t res;

  // register file, writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_height_r <= COLUMN_HEIGHT_RST;
      line_width_r    <= LINE_WIDTH_RST;
      line_number_r   <= LINE_NUMBER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_COLUMN_HEIGHT: column_height_r <= cfg_wdata[COLUMN_HEIGHT_W-1:0];
        CFG_LINE_WIDTH:    line_width_r    <= cfg_wdata[LINE_WIDTH_W-1:0];
        CFG_LINE_NUMBER:   line_number_r   <= cfg_wdata[LINE_NUMBER_W-1:0];
        default: ;
      endcase
    end
  end

  // output slot can take a letter this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign step      = pix_valid_r && out_free;
  assign in_tready = !pix_valid_r || out_free;

  always_comb begin
    pix_valid_nxt = pix_valid_r;
    if (in_tready) begin
      pix_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pix_valid_r <= pix_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pix_ink_r <= in_tdata[0];
    end
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  lcs_core #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .ink           (pix_ink_r),
    .column_height (column_height_r),
    .line_width    (line_width_r),
    .line_number   (line_number_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

endmodule

// File: hw/rtl/lcs_core.sv
// ----------------------------------------------------------------------------
// lcs_core: column scan state and letter closing logic
// Counts rows and columns, tracks the ink box and reports a closed letter.
// ----------------------------------------------------------------------------
module lcs_core import lcs_pkg::*; #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       ink,
  input  logic [COLUMN_HEIGHT_W-1:0] column_height,
  input  logic [LINE_WIDTH_W-1:0]    line_width,
  input  logic [LINE_NUMBER_W-1:0]   line_number,
  output logic                       res_valid,
  output lcs_result_t                res
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RW1 = RW + 1;
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned HW  = (RW1 > COLUMN_HEIGHT_W) ? RW1 : COLUMN_HEIGHT_W;
  localparam int unsigned WW  = (CW1 > LINE_WIDTH_W) ? CW1 : LINE_WIDTH_W;
  localparam logic [RW-1:0] BOX_TOP_IDLE = RW'(MAX_ROWS - 1);

  logic [RW-1:0]             row_r, row_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic                      has_ink_r, has_ink_nxt;
  logic                      in_letter_r, in_letter_nxt;
  logic [CW-1:0]             run_start_r, run_start_nxt;
  logic [RW-1:0]             top_r, top_nxt;
  logic [RW-1:0]             bot_r, bot_nxt;
  logic [LETTER_INDEX_W-1:0] letters_r, letters_nxt;

  logic [HW-1:0] h_used;
  logic [WW-1:0] w_used;
  logic          col_ink;
  logic [RW-1:0] top_upd, bot_upd;
  logic          col_end, line_end;
  logic          gap_emit, line_emit;
  logic [CW-1:0] run_start_eff;
  logic [CW1-1:0] width_gap, width_line;
  logic [RW1-1:0] height;

  // clamp registers into their usable range
  always_comb begin
    if (column_height == '0) begin
      h_used = HW'(1);
    end else if (HW'(column_height) > HW'(MAX_ROWS)) begin
      h_used = HW'(MAX_ROWS);
    end else begin
      h_used = HW'(column_height);
    end
    if (line_width == '0) begin
      w_used = WW'(1);
    end else if (WW'(line_width) > WW'(MAX_COLUMNS)) begin
      w_used = WW'(MAX_COLUMNS);
    end else begin
      w_used = WW'(line_width);
    end
  end

  assign col_ink  = has_ink_r | ink;
  assign top_upd  = (ink && (row_r < top_r)) ? row_r : top_r;
  assign bot_upd  = (ink && (row_r > bot_r)) ? row_r : bot_r;
  assign col_end  = (HW'(row_r) + HW'(1)) >= h_used;
  assign line_end = (WW'(col_r) + WW'(1)) >= w_used;

  assign gap_emit      = col_end && !col_ink && in_letter_r;
  assign run_start_eff = in_letter_r ? run_start_r : col_r;
  assign line_emit     = col_end && line_end && col_ink;

  assign width_gap  = CW1'(col_r) - CW1'(run_start_r);
  assign width_line = CW1'(col_r) - CW1'(run_start_eff) + CW1'(1);
  assign height     = RW1'(bot_upd) - RW1'(top_upd) + RW1'(1);

  assign res_valid = step && (gap_emit || line_emit);

  always_comb begin
    res.letter_index  = letters_r;
    res.start_column  = START_COLUMN_W'(run_start_eff);
    res.letter_width  = gap_emit ? LETTER_WIDTH_W'(width_gap) : LETTER_WIDTH_W'(width_line);
    res.top_row       = TOP_ROW_W'(top_upd);
    res.letter_height = LETTER_HEIGHT_W'(height);
    res.line_id       = line_number;
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    has_ink_nxt   = has_ink_r;
    in_letter_nxt = in_letter_r;
    run_start_nxt = run_start_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    letters_nxt   = letters_r;
    if (step) begin
      top_nxt = top_upd;
      bot_nxt = bot_upd;
      if (!col_end) begin
        row_nxt     = row_r + RW'(1);
        has_ink_nxt = col_ink;
      end else begin
        row_nxt     = '0;
        has_ink_nxt = 1'b0;
        if (col_ink && !in_letter_r) begin
          in_letter_nxt = 1'b1;
          run_start_nxt = col_r;
        end
        if (line_end) begin
          // close everything, next line starts clean
          in_letter_nxt = 1'b0;
          top_nxt       = BOX_TOP_IDLE;
          bot_nxt       = '0;
          col_nxt       = '0;
          letters_nxt   = '0;
        end else begin
          col_nxt = col_r + CW'(1);
          if (gap_emit) begin
            in_letter_nxt = 1'b0;
            top_nxt       = BOX_TOP_IDLE;
            bot_nxt       = '0;
            letters_nxt   = letters_r + LETTER_INDEX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      has_ink_r   <= 1'b0;
      in_letter_r <= 1'b0;
      run_start_r <= '0;
      top_r       <= BOX_TOP_IDLE;
      bot_r       <= '0;
      letters_r   <= '0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      has_ink_r   <= has_ink_nxt;
      in_letter_r <= in_letter_nxt;
      run_start_r <= run_start_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      letters_r   <= letters_nxt;
    end
  end

endmodule

// File: tb/sv/tb_letter_column_segmenter.sv
// ----------------------------------------------------------------------------
// tb_letter_column_segmenter: self-checking bench for the letter segmenter
// Streams ink pixels column by column and predicts every reported letter
// with a cycle-free model of the column and letter state. Results are
// checked in order, field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_letter_column_segmenter;
  import lcs_pkg::*;

  // sizes the block clamps its registers to
  localparam int unsigned ROW_LIMIT      = 1024;
  localparam int unsigned COLUMN_LIMIT   = 4096;
  // in_ accept to out_ valid, through the pixel and output registers
  localparam int unsigned PIPE_LATENCY   = 2;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  // random part runs until this many pixels are queued
  localparam int unsigned RANDOM_PIXELS  = 1000;
  // keeps random lines short
  localparam int unsigned LINE_PIXEL_CAP = 600;

  // how a generated column is filled
  typedef enum int {COL_BLANK, COL_GLYPH, COL_NOISE} column_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [0] ink, rest zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // letter_index, start_column,
                                             // letter_width, top_row,
                                             // letter_height, line_id, pad
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  letter_column_segmenter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // segmentation model: register copies and column/letter state
  // --------------------------------------------------------------------------
  logic [COLUMN_HEIGHT_W-1:0] rows_reg;
  logic [LINE_WIDTH_W-1:0]    cols_reg;
  logic [LINE_NUMBER_W-1:0]   line_reg;

  int unsigned row_pos;        // row of the next pixel within its column
  int unsigned col_pos;        // column of the next pixel within the line
  int unsigned run_first_col;  // first column of the open letter
  int unsigned ink_top;        // smallest ink row seen since the last close
  int unsigned ink_bottom;     // largest ink row seen since the last close
  int unsigned letter_seq;     // letters reported so far in this line
  bit          col_inked;
  bit          letter_open;

  lcs_result_t pending_letters[$];  // predicted letters not yet seen on out_
  bit          pixel_fifo[$];       // pixels waiting for the driver

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  // zero reads as one, anything above the limit as the limit
  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void close_letter(int unsigned span);
    lcs_result_t r;
    r.letter_index  = LETTER_INDEX_W'(letter_seq);
    r.start_column  = START_COLUMN_W'(run_first_col);
    r.letter_width  = LETTER_WIDTH_W'(span);
    r.top_row       = TOP_ROW_W'(ink_top);
    r.letter_height = LETTER_HEIGHT_W'(ink_bottom - ink_top + 1);
    r.line_id       = line_reg;
    pending_letters.push_back(r);
    letter_seq  = (letter_seq + 1) % (1 << LETTER_INDEX_W);
    letter_open = 1'b0;
    ink_top     = ROW_LIMIT - 1;
    ink_bottom  = 0;
  endfunction

  // one accepted pixel through the model
  function automatic void segment_pixel(bit ink);
    int unsigned rows;
    int unsigned cols;
    rows = clamp_size(rows_reg, ROW_LIMIT);
    cols = clamp_size(cols_reg, COLUMN_LIMIT);
    if (ink) begin
      col_inked = 1'b1;
      if (row_pos < ink_top) ink_top = row_pos;
      if (row_pos > ink_bottom) ink_bottom = row_pos;
    end
    // a lowered height ends the current column at once
    if (row_pos + 1 < rows) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    if (col_inked) begin
      if (!letter_open) begin
        letter_open   = 1'b1;
        run_first_col = col_pos;
      end
    end else if (letter_open) begin
      // first blank column after a run closes the letter
      close_letter(col_pos - run_first_col);
    end
    col_inked = 1'b0;
    if (col_pos + 1 >= cols) begin
      // end of line: a letter still open is closed including this column
      if (letter_open) close_letter(col_pos - run_first_col + 1);
      ink_top    = ROW_LIMIT - 1;
      ink_bottom = 0;
      col_pos    = 0;
      letter_seq = 0;
    end else begin
      col_pos++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: bursts of pixels from the fifo with random gaps between them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) segment_pixel(in_tdata[0]);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pixel_fifo.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(pixel_fifo.pop_front());
          if (burst_left == 0) begin
            // a third of the bursts run straight into the next one
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each letter against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  lcs_result_t seen;
  lcs_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = lcs_result_t'(out_tdata[$bits(lcs_result_t)-1:0]);
        if (pending_letters.size() == 0) begin
          $error("letter with no prediction waiting: %p", seen);
          error_count++;
        end else begin
          want = pending_letters.pop_front();
          check_field("letter_index", want.letter_index, seen.letter_index);
          check_field("start_column", want.start_column, seen.start_column);
          check_field("letter_width", want.letter_width, seen.letter_width);
          check_field("top_row", want.top_row, seen.top_row);
          check_field("letter_height", want.letter_height, seen.letter_height);
          check_field("line_id", want.line_id, seen.line_id);
        end
      end
      // stall pattern rotates with the cycle count: open, light, heavy, periodic
      case ((cycle_count >> 8) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((cycle_count % 11) < 5);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // register write, model copy follows; only called with the block idle
  task automatic write_register(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_COLUMN_HEIGHT: rows_reg = COLUMN_HEIGHT_W'(value);
      CFG_LINE_WIDTH:    cols_reg = LINE_WIDTH_W'(value);
      CFG_LINE_NUMBER:   line_reg = LINE_NUMBER_W'(value);
      default: ;
    endcase
  endtask

  task automatic program_line(int unsigned rows, int unsigned cols, int unsigned id);
    write_register(CFG_COLUMN_HEIGHT, rows);
    write_register(CFG_LINE_WIDTH, cols);
    write_register(CFG_LINE_NUMBER, id);
    @(negedge clk);
  endtask

  // all pixels accepted, all letters out, plus the pipeline's own depth
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_fifo.size() != 0 || in_tvalid || pending_letters.size() != 0);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // glyph columns get a random ink band, always inked at both band ends
  function automatic void push_column(int unsigned rows, column_kind_t kind);
    int unsigned top;
    int unsigned bottom;
    top    = $urandom_range(0, rows - 1);
    bottom = $urandom_range(top, rows - 1);
    for (int unsigned r = 0; r < rows; r++) begin
      case (kind)
        COL_BLANK: pixel_fifo.push_back(1'b0);
        COL_GLYPH: pixel_fifo.push_back(r == top || r == bottom ||
                                        (r > top && r < bottom && $urandom_range(0, 1)));
        default:   pixel_fifo.push_back(1'($urandom_range(0, 1)));
      endcase
    end
  endfunction

  function automatic column_kind_t pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return COL_BLANK;
    if (roll < 9) return COL_GLYPH;
    return COL_NOISE;
  endfunction

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  // two short lines, pixel i at bit i: a two-column letter closed by a blank
  // column, a letter open at the last column, and a letter closed by a blank
  // last column
  localparam logic [15:0] TWO_SHORT_LINES = 16'b0010_0000_1100_1001;

  int unsigned rows_pick;
  int unsigned cols_pick;
  int unsigned id_pick;
  int unsigned rows_eff;
  int unsigned cols_eff;
  int unsigned n_cols;
  int unsigned fifo_before;
  int unsigned random_pixels;

  initial begin
    rows_reg      = COLUMN_HEIGHT_RST;
    cols_reg      = LINE_WIDTH_RST;
    line_reg      = LINE_NUMBER_RST;
    row_pos       = 0;
    col_pos       = 0;
    run_first_col = 0;
    ink_top       = ROW_LIMIT - 1;
    ink_bottom    = 0;
    letter_seq    = 0;
    col_inked     = 1'b0;
    letter_open   = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: two-row, four-column lines, top line id
    program_line(2, 4, 16'hFFFF);
    for (int i = 0; i < 16; i++) pixel_fifo.push_back(TWO_SHORT_LINES[i]);
    wait_drained();

    // height lowered mid-column: row 1 of a three-row column ends it at once
    write_register(CFG_COLUMN_HEIGHT, 3);
    write_register(CFG_LINE_NUMBER, 0);
    @(negedge clk);
    pixel_fifo.push_back(1'b1);
    wait_drained();
    write_register(CFG_COLUMN_HEIGHT, 1);
    @(negedge clk);
    // ink on the cut column, then a blank column closes it, then two more
    // blank columns finish the four-column line
    pixel_fifo.push_back(1'b1);
    pixel_fifo.push_back(1'b0);
    pixel_fifo.push_back(1'b0);
    pixel_fifo.push_back(1'b0);
    wait_drained();

    // random lines: mostly small shapes, sometimes clamped registers,
    // partial lines and partial columns carry over into the next setting
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       rows_pick = 0;
        1:       rows_pick = 1;
        2:       rows_pick = $urandom_range(17, 40);
        default: rows_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       cols_pick = 0;
        1:       cols_pick = 1;
        2:       cols_pick = $urandom_range(25, 120);
        default: cols_pick = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 5))
        0:       id_pick = 0;
        1:       id_pick = 16'hFFFF;
        default: id_pick = $urandom_range(0, 65535);
      endcase
      rows_eff = clamp_size(rows_pick, ROW_LIMIT);
      cols_eff = clamp_size(cols_pick, COLUMN_LIMIT);
      if (rows_eff * cols_eff > LINE_PIXEL_CAP) begin
        cols_pick = LINE_PIXEL_CAP / rows_eff;
        cols_eff  = cols_pick;
      end
      program_line(rows_pick, cols_pick, id_pick);

      fifo_before = pixel_fifo.size();
      n_cols = cols_eff * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n_cols += $urandom_range(0, cols_eff - 1);
      if ($urandom_range(0, 7) == 0) begin
        // pure noise line
        for (int unsigned c = 0; c < n_cols; c++) push_column(rows_eff, COL_NOISE);
      end else begin
        for (int unsigned c = 0; c < n_cols; c++) push_column(rows_eff, pick_kind());
      end
      // stop part way into a column now and then
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, rows_eff)) pixel_fifo.push_back(1'($urandom_range(0, 1)));
      random_pixels += pixel_fifo.size() - fifo_before;
      wait_drained();
    end

    repeat (PIPE_LATENCY + 4) @(negedge clk);
    if (pending_letters.size() != 0) begin
      $error("%0d predicted letters never came out", pending_letters.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
